@@ hw/rtl/gcd_pkg.sv @@
package gcd_pkg;

  localparam int CordicSteps = 24;

  localparam logic signed [30:0] TurnU    = 31'sd754974720;
  localparam logic signed [30:0] HalfU    = 31'sd377487360;
  localparam logic signed [30:0] QuarterU = 31'sd188743680;

  localparam logic [63:0] RadQ40 = 64'd19190098069;
  localparam logic [17:0] RadHi  = RadQ40[34:17];
  localparam logic [16:0] RadLo  = RadQ40[16:0];

  localparam logic signed [32:0] GainQ30 = 33'sd652032874;
  localparam logic [30:0]        OneQ30  = 31'h4000_0000;
  localparam logic [12:0]        EarthR  = 13'd6371;
  localparam logic [22:0]        DistMax = 23'd5123863;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cordic_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [61:0] res;
  } root_t;

  function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
    logic signed [32:0] v;
    case (idx)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097141;
      5'd10: v = 33'sd1048575;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      5'd24: v = 33'sd64;
      5'd25: v = 33'sd32;
      5'd26: v = 33'sd16;
      5'd27: v = 33'sd8;
      5'd28: v = 33'sd4;
      5'd29: v = 33'sd2;
      5'd30: v = 33'sd1;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/great_circle_distance.sv @@
// Throughput: one request per cycle unless the output stalls; every stage is a register cell.
// Four rotation chains, two 31-cell square-root chains and one vectoring chain set the depth.
// The whole chain advances when the output register is empty or being taken.
// Reset clears only the valid bits; the data registers are not reset.
module great_circle_distance import gcd_pkg::*; #(
  parameter int CORDIC_STEPS = CordicSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata   // distance[22:0]
);

  localparam int N    = CORDIC_STEPS;
  localparam int Lat  = 42 + 2 * N;
  localparam int AIdx = 8 + N;

  logic               en;
  logic [Lat-1:0]     vld_q;
  logic signed [27:0] la_w, lb_w;
  logic signed [28:0] oa_w, ob_w;
  logic signed [30:0] d_q [4];
  logic signed [32:0] pz [4];
  logic               pn [4];
  cordic_t            rs [4][N+1];
  logic               rf [4][N+1];

  logic signed [65:0] sq1_w, sq2_w, pc_w, ccn_w, pc_q;
  logic signed [67:0] t_w;
  logic signed [33:0] ss1_q, ss2_q, ss1b_q, ss2b_q, ss1c_q, cc_q, t_q;
  logic               ng_q;
  logic signed [34:0] hs_w;
  logic [30:0]        a_q;

  root_t              ry [32];
  root_t              rx [32];
  cordic_t            vs [N+1];
  logic               vf [N+1];

  logic [31:0]        zc_w;
  logic [44:0]        prod_q;
  logic [45:0]        rnd_w;
  logic [22:0]        dist_q;

  assign en            = ~vld_q[Lat-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {1'b0, dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  assign la_w = s_axis_tdata[27:0];
  assign oa_w = s_axis_tdata[56:28];
  assign lb_w = s_axis_tdata[84:57];
  assign ob_w = s_axis_tdata[113:85];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= 31'(lb_w) - 31'(la_w);
      d_q[1] <= 31'(ob_w) - 31'(oa_w);
      d_q[2] <= 31'(la_w) <<< 1;
      d_q[3] <= 31'(lb_w) <<< 1;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rot
    gcd_angle_prep u_prep (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (d_q[k]),
      .z_o   (pz[k]),
      .neg_o (pn[k])
    );
    assign rs[k][0].x = GainQ30;
    assign rs[k][0].y = '0;
    assign rs[k][0].z = pz[k];
    assign rf[k][0]   = pn[k];
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(.VECTOR(1'b0), .STEP(i)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .st_i   (rs[k][i]),
        .flag_i (rf[k][i]),
        .st_o   (rs[k][i+1]),
        .flag_o (rf[k][i+1])
      );
    end
  end

  assign sq1_w = rs[0][N].y * rs[0][N].y;
  assign sq2_w = rs[1][N].y * rs[1][N].y;
  assign pc_w  = rs[2][N].x * rs[3][N].x;
  assign ccn_w = ng_q ? -pc_q : pc_q;
  assign t_w   = cc_q * ss2b_q;
  assign hs_w  = 35'(ss1c_q) + 35'(t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss1_q  <= sq1_w[63:30];
      ss2_q  <= sq2_w[63:30];
      pc_q   <= pc_w;
      ng_q   <= rf[2][N] ^ rf[3][N];
      cc_q   <= ccn_w[63:30];
      ss1b_q <= ss1_q;
      ss2b_q <= ss2_q;
      t_q    <= t_w[63:30];
      ss1c_q <= ss1b_q;
      if (hs_w < 0) begin
        a_q <= '0;
      end else if (hs_w > 35'(OneQ30)) begin
        a_q <= OneQ30;
      end else begin
        a_q <= hs_w[30:0];
      end
    end
  end

  assign ry[0].rem = {a_q, 30'd0};
  assign ry[0].res = '0;
  assign rx[0].rem = {OneQ30 - a_q, 30'd0};
  assign rx[0].res = '0;

  for (genvar i = 0; i < 31; i++) begin : g_root
    gcd_sqrt_cell #(.STEP(i)) u_ry (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (ry[i]),
      .st_o  (ry[i+1])
    );
    gcd_sqrt_cell #(.STEP(i)) u_rx (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (rx[i]),
      .st_o  (rx[i+1])
    );
  end

  assign vs[0].x = {2'b00, rx[31].res[30:0]};
  assign vs[0].y = {2'b00, ry[31].res[30:0]};
  assign vs[0].z = '0;
  assign vf[0]   = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_cordic_cell #(.VECTOR(1'b1), .STEP(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .st_i   (vs[i]),
      .flag_i (vf[i]),
      .st_o   (vs[i+1]),
      .flag_o (vf[i+1])
    );
  end

  assign zc_w  = vs[N].z[32] ? 32'd0 : vs[N].z[31:0];
  assign rnd_w = 46'(prod_q) + 46'h10_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 45'(zc_w) * 45'(EarthR);
      if (rnd_w[45:21] > 25'(DistMax)) begin
        dist_q <= DistMax;
      end else begin
        dist_q <= rnd_w[43:21];
      end
    end
  end

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted request did not enter the first stage");

  a_hav_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[AIdx] |-> (a_q <= OneQ30))
    else $error("haversine term above one");

  a_dist_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dist_q <= DistMax))
    else $error("distance above half the circumference");

endmodule

@@ hw/rtl/gcd_angle_prep.sv @@
module gcd_angle_prep import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [30:0] d_i,
  output logic signed [32:0] z_o,
  output logic               neg_o
);

  logic signed [30:0] r_d, r_q;
  logic signed [30:0] f_w;
  logic               nc_w;
  logic [27:0]        m_d, m_q;
  logic               nc2_q, nc3_q, nc4_q;
  logic [45:0]        phi_q;
  logic [44:0]        plo_q;
  logic [63:0]        sum_w;
  logic signed [32:0] z_q;

  always_comb begin
    if (d_i < -HalfU) begin
      r_d = d_i + TurnU;
    end else if (d_i >= HalfU) begin
      r_d = d_i - TurnU;
    end else begin
      r_d = d_i;
    end
  end

  always_comb begin
    nc_w = 1'b0;
    f_w  = r_q;
    if (r_q > QuarterU) begin
      f_w  = HalfU - r_q;
      nc_w = 1'b1;
    end else if (r_q < -QuarterU) begin
      f_w  = -HalfU - r_q;
      nc_w = 1'b1;
    end
    m_d = f_w[30] ? 28'(-f_w) : 28'(f_w);
  end

  assign sum_w = {1'b0, phi_q, 17'd0} + 64'(plo_q) + 64'h4000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r_d;
      m_q   <= m_d;
      nc2_q <= nc_w;
      phi_q <= 46'(m_q) * 46'(RadHi);
      plo_q <= 45'(m_q) * 45'(RadLo);
      nc3_q <= nc2_q;
      z_q   <= {1'b0, sum_w[62:31]};
      nc4_q <= nc3_q;
    end
  end

  assign z_o   = z_q;
  assign neg_o = nc4_q;

endmodule

@@ hw/rtl/gcd_cordic_cell.sv @@
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter bit VECTOR = 1'b0,
  parameter int STEP   = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t st_i,
  input  logic    flag_i,
  output cordic_t st_o,
  output logic    flag_o
);

  cordic_t            st_d, st_q;
  logic               flag_q;
  logic signed [32:0] dx, dy, at;
  logic               fwd;

  always_comb begin
    dx  = st_i.y >>> STEP;
    dy  = st_i.x >>> STEP;
    at  = atan_q30(5'(STEP));
    fwd = VECTOR ? st_i.y[32] : ~st_i.z[32];
    if (fwd) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - at;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      flag_q <= flag_i;
    end
  end

  assign st_o   = st_q;
  assign flag_o = flag_q;

endmodule

@@ hw/rtl/gcd_sqrt_cell.sv @@
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  root_t st_i,
  output root_t st_o
);

  localparam logic [61:0] Bit = 62'(1) << (60 - 2 * STEP);

  root_t       st_d, st_q;
  logic [61:0] sum;

  always_comb begin
    sum = st_i.res + Bit;
    if ({1'b0, st_i.rem} >= sum) begin
      st_d.rem = st_i.rem - sum[60:0];
      st_d.res = (st_i.res >> 1) + Bit;
    end else begin
      st_d.rem = st_i.rem;
      st_d.res = st_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule
